/* rtl/c2c_pkg.sv */
// shared types and constants for the cartesian to cylindrical converter
`default_nettype none

package c2c_pkg;

    // datapath width of the rotation stages, operands are scaled to about 2^59
    localparam int CW         = 64;
    // scaled operands carry this many bits above the binary point of the input
    localparam int SCALE_BASE = 60;
    // angle accumulator: degrees with 30 fraction bits, signed
    localparam int ACC_W      = 40;
    localparam int ACC_FRAC   = 30;
    localparam int TABLE_LEN  = 15;

    localparam longint DEG_PER_RAD_Q30 = 64'sd61520874802;
    localparam logic signed [ACC_W-1:0] ACC_180 = 40'sd193273528320;
    localparam logic signed [ACC_W-1:0] ACC_360 = 40'sd386547056640;

    // atan(2^-i) in degrees, 30 fraction bits
    localparam longint ATAN_TAB [0:TABLE_LEN-1] = '{
        64'sd48318382080, 64'sd28524006506, 64'sd15071301663, 64'sd7650428050,
        64'sd3840059795,  64'sd1921901881,  64'sd961185452,   64'sd480622056,
        64'sd240314695,   64'sd120157806,   64'sd60078960,    64'sd30039487,
        64'sd15019745,    64'sd7509872,     64'sd3754936
    };

    // fixed answers for points on the axes
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_0,
        SPEC_90,
        SPEC_180,
        SPEC_270
    } t_spec;

    // rotation angle of stage i, beyond the table atan(2^-i) ~ 2^-i rad
    function automatic longint stage_angle(input int i);
        longint one;
        one = 64'sd1;
        if (i < TABLE_LEN) begin
            return ATAN_TAB[i];
        end
        return (DEG_PER_RAD_Q30 + (one <<< (i - 1))) >>> i;
    endfunction

endpackage

`default_nettype wire

/* rtl/cartesian_to_cylindrical_core.sv */
// Cartesian to cylindrical conversion: radius, azimuth in degrees, height.
// One point is taken in every clock cycle (busy is always low) and its result
// leaves the pipeline marked by o_valid for one cycle. The latency is set by
// the longer of two parallel pipelines: the CORDIC vectoring chain (one
// rotation stage per register) and the integer square root (one root bit per
// register); the shorter one is padded with a delay line. The radius is
// sqrt(x^2 + y^2) rounded to nearest, the angle lies in [0, 360) with
// ANGLE_FRAC_BITS fraction bits and is exact on the axes (90 for x zero and y
// non-negative, 270 for x zero and y negative, 0 or 180 for y zero). The
// result must be taken in the cycle it is shown.
`default_nettype none

module cartesian_to_cylindrical_core #(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 24
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  signed [COORD_WIDTH-1:0]         i_coord_x,
    input  wire  signed [COORD_WIDTH-1:0]         i_coord_y,
    input  wire  signed [COORD_WIDTH-1:0]         i_coord_z,
    output logic                                  o_valid,
    output logic        [COORD_WIDTH-1:0]         o_radius,
    output logic        [ANGLE_FRAC_BITS+8:0]     o_angle_deg,
    output logic signed [COORD_WIDTH-1:0]         o_height
);

    localparam int W      = COORD_WIDTH;
    localparam int N      = CORDIC_STAGES;
    localparam int CW     = c2c_pkg::CW;
    localparam int AW     = c2c_pkg::ACC_W;
    localparam int SCALE  = c2c_pkg::SCALE_BASE - W;
    localparam int SH     = c2c_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
    localparam int RES_W  = ANG_W + 1;
    localparam int P_END  = N + 3;
    localparam int R_END  = W + 4;
    localparam int END    = (P_END > R_END) ? P_END : R_END;
    localparam int LAT    = END + 1;
    localparam int DA     = END - P_END;
    localparam int DR     = END - R_END;

    localparam logic signed [AW-1:0] HALF     = AW'(64'sd1 <<< (SH - 1));
    localparam logic        [RES_W-1:0] FULL  = RES_W'(360) << ANGLE_FRAC_BITS;
    localparam logic        [ANG_W-1:0] A_FULL = ANG_W'(360) << ANGLE_FRAC_BITS;
    localparam logic        [ANG_W-1:0] A_90   = ANG_W'(90) << ANGLE_FRAC_BITS;
    localparam logic        [ANG_W-1:0] A_180  = ANG_W'(180) << ANGLE_FRAC_BITS;
    localparam logic        [ANG_W-1:0] A_270  = ANG_W'(270) << ANGLE_FRAC_BITS;

    // no back-pressure anywhere, a transaction can start every cycle
    assign busy = 1'b0;

    // ---------------------------------------------------------------- control
    logic                r_vld [0:END];
    logic signed [W-1:0] r_z   [0:END];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= END; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start & ~busy;
            for (int i = 1; i <= END; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_z[0] <= i_coord_z;
        for (int i = 1; i <= END; i++) begin
            r_z[i] <= r_z[i-1];
        end
    end

    // ------------------------------------------------------------ input stage
    logic signed [W-1:0] r_in_x;
    logic signed [W-1:0] r_in_y;

    always_ff @(posedge i_clk) begin
        r_in_x <= i_coord_x;
        r_in_y <= i_coord_y;
    end

    // ------------------------------------------------------------ angle path
    logic signed [CW-1:0]  r_cx   [0:N];
    logic signed [CW-1:0]  r_cy   [0:N];
    logic signed [AW-1:0]  r_acc  [0:N];
    c2c_pkg::t_spec        r_spec [0:N];

    logic signed [CW-1:0]  n_xe;
    logic signed [CW-1:0]  n_ye;
    logic signed [AW-1:0]  n_acc0;
    c2c_pkg::t_spec        n_spec0;

    // left half plane is turned by 180 degrees first
    always_comb begin
        n_xe   = CW'(r_in_x);
        n_ye   = CW'(r_in_y);
        n_acc0 = '0;
        if (r_in_x[W-1]) begin
            n_xe   = -n_xe;
            n_ye   = -n_ye;
            n_acc0 = c2c_pkg::ACC_180;
        end
        priority if (r_in_x == '0) begin
            n_spec0 = r_in_y[W-1] ? c2c_pkg::SPEC_270 : c2c_pkg::SPEC_90;
        end else if (r_in_y == '0) begin
            n_spec0 = r_in_x[W-1] ? c2c_pkg::SPEC_180 : c2c_pkg::SPEC_0;
        end else begin
            n_spec0 = c2c_pkg::SPEC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0]   <= n_xe <<< SCALE;
        r_cy[0]   <= n_ye <<< SCALE;
        r_acc[0]  <= n_acc0;
        r_spec[0] <= n_spec0;
    end

    for (genvar k = 0; k < N; k++) begin : g_cordic
        localparam logic signed [AW-1:0] ANG = AW'(c2c_pkg::stage_angle(k));
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        // arithmetic shifts round toward minus infinity
        assign xs = r_cx[k] >>> k;
        assign ys = r_cy[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!r_cy[k][CW-1]) begin
                r_cx[k+1]  <= r_cx[k] + ys;
                r_cy[k+1]  <= r_cy[k] - xs;
                r_acc[k+1] <= r_acc[k] + ANG;
            end else begin
                r_cx[k+1]  <= r_cx[k] - ys;
                r_cy[k+1]  <= r_cy[k] + xs;
                r_acc[k+1] <= r_acc[k] - ANG;
            end
            r_spec[k+1] <= r_spec[k];
        end
    end

    // fold negative angles up by 360 and add the rounding half in one add
    logic signed [AW-1:0] r_wsum;
    c2c_pkg::t_spec       r_wspec;

    always_ff @(posedge i_clk) begin
        r_wsum  <= r_acc[N] + (r_acc[N][AW-1] ? (c2c_pkg::ACC_360 + HALF) : HALF);
        r_wspec <= r_spec[N];
    end

    logic [RES_W-1:0] w_res;
    logic [ANG_W-1:0] n_ang;
    logic [ANG_W-1:0] r_ang;

    assign w_res = r_wsum[AW-1:SH];

    always_comb begin
        unique case (r_wspec)
            c2c_pkg::SPEC_0:   n_ang = '0;
            c2c_pkg::SPEC_90:  n_ang = A_90;
            c2c_pkg::SPEC_180: n_ang = A_180;
            c2c_pkg::SPEC_270: n_ang = A_270;
            default: begin
                // rounding up to 360 wraps to 0
                if (w_res >= FULL) begin
                    n_ang = ANG_W'(w_res - FULL);
                end else begin
                    n_ang = ANG_W'(w_res);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ang <= n_ang;
    end

    // ----------------------------------------------------------- radius path
    logic [W-1:0]   r_ax;
    logic [W-1:0]   r_ay;
    logic [2*W-1:0] r_sx;
    logic [2*W-1:0] r_sy;

    always_ff @(posedge i_clk) begin
        r_ax <= r_in_x[W-1] ? W'(-r_in_x) : W'(r_in_x);
        r_ay <= r_in_y[W-1] ? W'(-r_in_y) : W'(r_in_y);
        r_sx <= {{W{1'b0}}, r_ax} * {{W{1'b0}}, r_ax};
        r_sy <= {{W{1'b0}}, r_ay} * {{W{1'b0}}, r_ay};
    end

    logic [W-1:0]   r_q   [0:W];
    logic [W+1:0]   r_rem [0:W];
    logic [2*W-1:0] r_sv  [0:W];

    // sum cannot exceed 2^(2W-1), so no carry out
    always_ff @(posedge i_clk) begin
        r_sv[0]  <= r_sx + r_sy;
        r_q[0]   <= '0;
        r_rem[0] <= '0;
    end

    // restoring square root, one root bit per stage
    for (genvar j = 0; j < W; j++) begin : g_sqrt
        logic [W+1:0] rem_sh;
        logic [W+1:0] trial;

        assign rem_sh = {r_rem[j][W-1:0], r_sv[j][2*W-1:2*W-2]};
        assign trial  = {r_q[j], 2'b01};

        always_ff @(posedge i_clk) begin
            if (rem_sh >= trial) begin
                r_rem[j+1] <= rem_sh - trial;
                r_q[j+1]   <= {r_q[j][W-2:0], 1'b1};
            end else begin
                r_rem[j+1] <= rem_sh;
                r_q[j+1]   <= {r_q[j][W-2:0], 1'b0};
            end
            r_sv[j+1] <= r_sv[j] << 2;
        end
    end

    logic [W-1:0] r_rad;

    // round to nearest: remainder above the floor root means bump by one
    always_ff @(posedge i_clk) begin
        if (r_rem[W] > {2'b00, r_q[W]}) begin
            r_rad <= r_q[W] + W'(1);
        end else begin
            r_rad <= r_q[W];
        end
    end

    // ----------------------------------------------------------- alignment
    logic [ANG_W-1:0] w_ang_out;
    logic [W-1:0]     w_rad_out;

    if (DA > 0) begin : g_adly
        logic [ANG_W-1:0] r_adly [0:DA-1];
        always_ff @(posedge i_clk) begin
            r_adly[0] <= r_ang;
            for (int i = 1; i < DA; i++) begin
                r_adly[i] <= r_adly[i-1];
            end
        end
        assign w_ang_out = r_adly[DA-1];
    end else begin : g_anodly
        assign w_ang_out = r_ang;
    end

    if (DR > 0) begin : g_rdly
        logic [W-1:0] r_rdly [0:DR-1];
        always_ff @(posedge i_clk) begin
            r_rdly[0] <= r_rad;
            for (int i = 1; i < DR; i++) begin
                r_rdly[i] <= r_rdly[i-1];
            end
        end
        assign w_rad_out = r_rdly[DR-1];
    end else begin : g_rnodly
        assign w_rad_out = r_rad;
    end

    assign o_valid     = r_vld[END];
    assign o_radius    = w_rad_out;
    assign o_angle_deg = w_ang_out;
    assign o_height    = r_z[END];

    // ----------------------------------------------------------- assertions
`ifndef ASSERT_OFF
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without a transaction");

    a_height_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_height == $past(i_coord_z, LAT)))
        else $error("height not aligned with its transaction");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_deg < A_FULL))
        else $error("angle at or above 360 degrees");

    a_y_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_coord_x, LAT) == '0))
            |-> ((o_angle_deg == A_90) || (o_angle_deg == A_270)))
        else $error("point on the y axis gave a wrong angle");
`endif

endmodule

`default_nettype wire
